[sv/vdu_pkg.sv]
// vdu_pkg: shared constants and the controller/datapath command and status structs.
// No dependencies.
package vdu_pkg;

	localparam int unsigned MAX_DIM_DEF = 4096;
	localparam int unsigned SUM_W = 45;
	localparam int unsigned DOT_W = 44;
	localparam int unsigned NRM_W = 43;
	localparam int unsigned DIST_W = 46;
	localparam int unsigned ROOT_BITS = 45;
	localparam int unsigned QUO_BITS = 18;

	localparam logic [1:0] METRIC_L2 = 2'd0;
	localparam logic [1:0] METRIC_COS = 2'd1;
	localparam logic [1:0] METRIC_IP = 2'd2;

	typedef struct packed {
		logic accum;
		logic sel_cos;
		logic prod_ld;
		logic root_ld;
		logic root_step;
		logic div_ld;
		logic div_step;
		logic finish;
	} vdu_cmd_t;

	typedef struct packed {
		logic zero_den;
	} vdu_sts_t;

endpackage

[sv/vector_distance_unit.sv]
// vector_distance_unit: top level, metric register, controller and datapath.
// Depends on vdu_pkg, vdu_ctrl, vdu_datapath.
//
// Usage: one element pair per input beat (elem_a, elem_b, last), accepted on
// in_valid high and in_stall low. Elements are taken one a cycle while the
// input is not stalled. The beat with last set closes the vector: the input
// stalls until the distance beat (distance, out_valid) is taken, then all sums
// clear. For L2 and inner product out_valid rises in the cycle after the last
// beat. Cosine first builds the norm product; with a zero norm the result
// follows, else it takes a bit-serial square root of the 86-bit norm
// product, then a bit-serial divide of the 60-bit scaled dot sum.
// A held out_stall keeps distance steady and the input stalled.
// metric is written via metric_we / metric_wdata; the user must do so only while idle, the block does not enforce it.
// Reset clears the sums, the metric (squared L2) and the sequencer.
module vector_distance_unit #(
	parameter int unsigned MAX_DIM = vdu_pkg::MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               metric_we,
	input  logic [1:0]         metric_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] elem_a,
	input  logic signed [15:0] elem_b,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [45:0] distance
);
	logic [1:0] metric_q;
	vdu_pkg::vdu_cmd_t cmd;
	vdu_pkg::vdu_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			metric_q <= vdu_pkg::METRIC_L2;
		else if (metric_we)
			metric_q <= metric_wdata;
	end

	vdu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_last(last), .out_valid(out_valid), .out_stall(out_stall),
		.metric_q(metric_q), .sts(sts), .cmd(cmd)
	);

	vdu_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.elem_a(elem_a), .elem_b(elem_b), .metric_q(metric_q), .result(distance)
	);

`ifndef SYNTHESIS
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken while result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(distance))
		else $error("result dropped under stall");
	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && metric_q == vdu_pkg::METRIC_COS |->
		distance >= 0 && distance <= 46'sd131072) else $error("cosine out of range");
`endif
endmodule

[sv/vdu_datapath.sv]
// vdu_datapath: accumulators, the 86-bit norm product, bit-serial root and divider.
// Depends on vdu_pkg.
module vdu_datapath #(
	parameter int unsigned MAX_DIM = vdu_pkg::MAX_DIM_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vdu_pkg::vdu_cmd_t           cmd,
	output vdu_pkg::vdu_sts_t           sts,
	input  logic signed [15:0]          elem_a,
	input  logic signed [15:0]          elem_b,
	input  logic [1:0]                  metric_q,
	output logic signed [vdu_pkg::DIST_W-1:0] result
);
	localparam int unsigned SW = vdu_pkg::SUM_W;
	localparam int unsigned DW = vdu_pkg::DOT_W;
	localparam int unsigned NW = vdu_pkg::NRM_W;
	localparam int unsigned RB = vdu_pkg::ROOT_BITS;
	localparam int unsigned QB = vdu_pkg::QUO_BITS;
	localparam logic [63:0] LIM_L2_RAW = 64'(MAX_DIM) * 64'd4294836225;
	localparam logic [63:0] LIM_N_RAW = 64'(MAX_DIM) * 64'd1073741824;
	localparam logic [63:0] W45MAX = (64'd1 << 45) - 64'd1;
	localparam logic [63:0] W43MAX = (64'd1 << 43) - 64'd1;
	localparam logic [SW-1:0] LIM_L2 = SW'((LIM_L2_RAW < W45MAX) ? LIM_L2_RAW : W45MAX);
	localparam logic [NW-1:0] LIM_N = NW'((LIM_N_RAW < W43MAX) ? LIM_N_RAW : W43MAX);

	logic [SW-1:0] dsq_q;
	logic signed [DW-1:0] dot_q;
	logic [NW-1:0] na_q, nb_q;

	logic signed [16:0] d;
	logic [33:0] dd;
	logic [31:0] aa, bb;
	logic signed [31:0] ab;
	logic [SW:0] dsq_n;
	logic [NW:0] na_n, nb_n;
	logic signed [DW:0] dot_n;

	assign d = 17'(elem_a) - 17'(elem_b);
	assign dd = 34'(d * d);
	assign aa = 32'(elem_a * elem_a);
	assign bb = 32'(elem_b * elem_b);
	assign ab = elem_a * elem_b;
	assign dsq_n = {1'b0, dsq_q} + (SW+1)'(dd);
	assign na_n = {1'b0, na_q} + (NW+1)'(aa);
	assign nb_n = {1'b0, nb_q} + (NW+1)'(bb);
	assign dot_n = (DW+1)'(dot_q) + (DW+1)'(ab);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsq_q <= '0;
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
		end else if (cmd.finish) begin
			dsq_q <= '0;
			dot_q <= '0;
			na_q <= '0;
			nb_q <= '0;
		end else if (cmd.accum) begin
			dsq_q <= (dsq_n > (SW+1)'(LIM_L2)) ? LIM_L2 : dsq_n[SW-1:0];
			na_q <= (na_n > (NW+1)'(LIM_N)) ? LIM_N : na_n[NW-1:0];
			nb_q <= (nb_n > (NW+1)'(LIM_N)) ? LIM_N : nb_n[NW-1:0];
			if (dot_n > $signed((DW+1)'(LIM_N)))
				dot_q <= DW'(LIM_N);
			else if (dot_n < -$signed((DW+1)'(LIM_N)))
				dot_q <= -DW'(LIM_N);
			else
				dot_q <= dot_n[DW-1:0];
		end
	end

	// norm product built from two 22-bit chunks of na_q, one 22x43 multiply a cycle
	localparam int unsigned PW = 2 * NW;
	logic [PW-1:0] prod_q;
	logic [1:0] pcnt_q;
	logic pbusy_q;
	logic [21:0] chunk;
	logic [64:0] part;

	always_comb begin
		case (pcnt_q)
			2'd0: chunk = na_q[21:0];
			default: chunk = {1'b0, na_q[42:22]};
		endcase
	end
	assign part = 65'(chunk) * 65'(nb_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			pbusy_q <= 1'b0;
		end else if (cmd.prod_ld) begin
			pcnt_q <= 2'd0;
			pbusy_q <= 1'b1;
		end else if (pbusy_q) begin
			pcnt_q <= pcnt_q + 2'd1;
			if (pcnt_q == 2'd1)
				pbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prod_ld)
			prod_q <= '0;
		else if (pbusy_q) begin
			if (pcnt_q == 2'd0)
				prod_q <= PW'(part);
			else
				prod_q <= prod_q + (PW'(part) << 22);
		end
	end

	// restoring square root, one result bit per step; radicand padded to 2*RB bits
	logic [RB-1:0] root_q;
	logic [PW+1:0] rem_q;
	logic [PW+3:0] rad_q;
	logic [PW+1:0] trial;
	logic [PW+1:0] rem_sh;

	assign rem_sh = {rem_q[PW-1:0], rad_q[PW+3:PW+2]};
	assign trial = (PW+2)'({root_q, 2'b01});

	always_ff @(posedge clk) begin
		if (cmd.root_ld) begin
			root_q <= '0;
			rem_q <= '0;
			rad_q <= {4'd0, prod_q};
		end else if (cmd.root_step) begin
			rad_q <= {rad_q[PW+1:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q <= rem_sh - trial;
				root_q <= {root_q[RB-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				root_q <= {root_q[RB-2:0], 1'b0};
			end
		end
	end

	// restoring divider for (|dot| << 16) / root, with quotient saturation
	localparam int unsigned NUMW = DW + 16;
	logic [NUMW-1:0] num_q;
	logic [RB:0] drem_q;
	logic [QB:0] quo_q;
	logic [RB:0] drem_sh;
	logic neg_q;
	logic [DW-1:0] mag;

	assign mag = dot_q[DW-1] ? DW'(-dot_q) : DW'(dot_q);
	assign drem_sh = {drem_q[RB-1:0], num_q[NUMW-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_ld) begin
			num_q <= {mag, 16'd0};
			drem_q <= '0;
			quo_q <= '0;
			neg_q <= dot_q[DW-1];
		end else if (cmd.div_step) begin
			num_q <= {num_q[NUMW-2:0], 1'b0};
			if (drem_sh >= {1'b0, root_q}) begin
				drem_q <= drem_sh - {1'b0, root_q};
				quo_q <= quo_q[QB] ? quo_q : {quo_q[QB-1:0], 1'b1};
			end else begin
				drem_q <= drem_sh;
				quo_q <= quo_q[QB] ? quo_q : {quo_q[QB-1:0], 1'b0};
			end
		end
	end

	logic [QB:0] qc;
	logic signed [QB+2:0] cres;
	assign qc = (quo_q > (QB+1)'(131072)) ? (QB+1)'(131072) : quo_q;
	always_comb begin
		if (sts.zero_den)
			cres = (QB+3)'(65536);
		else if (neg_q)
			cres = (QB+3)'(65536) + (QB+3)'(qc);
		else
			cres = (QB+3)'(65536) - (QB+3)'(qc);
		if (cres < 0)
			cres = '0;
		if (cres > (QB+3)'(131072))
			cres = (QB+3)'(131072);
	end

	// root zero only when product zero, so the norm test covers it
	assign sts.zero_den = (na_q == '0) || (nb_q == '0);

	always_comb begin
		unique case (metric_q)
			vdu_pkg::METRIC_COS: result = vdu_pkg::DIST_W'(cres);
			vdu_pkg::METRIC_IP:  result = -vdu_pkg::DIST_W'(dot_q);
			default:             result = vdu_pkg::DIST_W'(dsq_q);
		endcase
	end
endmodule

[sv/vdu_ctrl.sv]
// vdu_ctrl: sequencer for accumulate, cosine finish and result hand-off.
// Depends on vdu_pkg.
module vdu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              in_last,
	output logic              out_valid,
	input  logic              out_stall,
	input  logic [1:0]        metric_q,
	input  vdu_pkg::vdu_sts_t sts,
	output vdu_pkg::vdu_cmd_t cmd
);
	localparam logic [2:0] ST_ACC = 3'd0;
	localparam logic [2:0] ST_PROD = 3'd1;
	localparam logic [2:0] ST_ROOT = 3'd2;
	localparam logic [2:0] ST_DIV = 3'd3;
	localparam logic [2:0] ST_OUT = 3'd4;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic take;

	assign in_stall = (state_q != ST_ACC);
	assign take = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.accum = take;
		cmd.prod_ld = take && in_last && (metric_q == vdu_pkg::METRIC_COS);
		cmd.root_ld = (state_q == ST_PROD) && (cnt_q == 6'd2);
		cmd.root_step = (state_q == ST_ROOT);
		cmd.div_ld = (state_q == ST_ROOT) && (cnt_q == 6'd0);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish = out_valid && !out_stall;
		cmd.sel_cos = (metric_q == vdu_pkg::METRIC_COS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACC;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_ACC: if (take && in_last) begin
					if (cmd.sel_cos) begin
						state_q <= ST_PROD;
						cnt_q <= '0;
					end else
						state_q <= ST_OUT;
				end
				ST_PROD: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd2) begin
						if (sts.zero_den)
							state_q <= ST_OUT;
						else begin
							state_q <= ST_ROOT;
							cnt_q <= 6'(vdu_pkg::ROOT_BITS - 1);
						end
					end
				end
				ST_ROOT: begin
					if (cnt_q == 6'd0) begin
						state_q <= ST_DIV;
						cnt_q <= 6'(vdu_pkg::DOT_W + 16 - 1);
					end else
						cnt_q <= cnt_q - 6'd1;
				end
				ST_DIV: begin
					if (cnt_q == 6'd0)
						state_q <= ST_OUT;
					else
						cnt_q <= cnt_q - 6'd1;
				end
				ST_OUT: if (!out_stall)
					state_q <= ST_ACC;
				default: state_q <= ST_ACC;
			endcase
		end
	end
endmodule
